>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the affine point adder.
// No dependencies; included by the modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, masked while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

>>> rtl/ecpa_pkg.sv
// Package for the affine point adder: field width, beat structs, ALU request.
// No dependencies.
`timescale 1ns / 1ps

package ecpa_pkg;

  localparam int FIELD_BITS = 16;
  localparam int SHIFT_BITS = $clog2(FIELD_BITS);

  localparam logic [FIELD_BITS-1:0] MODULUS_RESET = FIELD_BITS'(97);
  localparam logic [FIELD_BITS-1:0] CURVE_A_RESET = FIELD_BITS'(2);

  // input beat: two affine points with infinity flags
  typedef struct packed {
    logic                  first_inf;
    logic [FIELD_BITS-1:0] first_x;
    logic [FIELD_BITS-1:0] first_y;
    logic                  second_inf;
    logic [FIELD_BITS-1:0] second_x;
    logic [FIELD_BITS-1:0] second_y;
  } points_t;

  // output beat: the sum
  typedef struct packed {
    logic                  sum_inf;
    logic [FIELD_BITS-1:0] sum_x;
    logic [FIELD_BITS-1:0] sum_y;
    logic                  bad_input;
  } sum_t;

  // modular ALU operations
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MSTEP
  } alu_op_t;

  // request to the shared modular ALU
  typedef struct packed {
    alu_op_t               op;
    logic [FIELD_BITS-1:0] a;
    logic [FIELD_BITS-1:0] b;
    logic [FIELD_BITS-1:0] p;
    logic                  mbit;
  } alu_req_t;

endpackage

>>> rtl/ec_affine_point_add.sv
// Affine point adder over a prime field; depends on ecpa_pkg, ecpa_modalu.
// Infinity, bad-input and inverse-pair beats go straight to the output stage; chord add and
// doubling run the sequencer first, with a modular inverse by shift-subtract extended Euclid.
// One beat at a time: next beat taken the cycle after the sum loads, later under back-pressure.
// Synchronous active-high reset: modulus 97, curve_a 2, channels empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ec_affine_point_add (
  input  logic                  clk,
  input  logic                  rst,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input points
  input  logic                  points_valid,
  output logic                  points_ready,
  input  ecpa_pkg::points_t     points,
  // result
  output logic                  sum_valid,
  input  logic                  sum_ready,
  output ecpa_pkg::sum_t        sum
);
  import ecpa_pkg::*;

  localparam int W  = FIELD_BITS;
  localparam int KW = SHIFT_BITS;
  localparam int SW = FIELD_BITS + 2;

  localparam logic [0:0] REG_MODULUS = 1'b0;
  localparam logic [0:0] REG_CURVE_A = 1'b1;

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_MUL       = 5'd1;
  localparam logic [4:0] ST_AR        = 5'd2;
  localparam logic [4:0] ST_SQ        = 5'd3;
  localparam logic [4:0] ST_T3        = 5'd4;
  localparam logic [4:0] ST_TA        = 5'd5;
  localparam logic [4:0] ST_DDEN      = 5'd6;
  localparam logic [4:0] ST_CNUM      = 5'd7;
  localparam logic [4:0] ST_CDEN      = 5'd8;
  localparam logic [4:0] ST_INV_TEST  = 5'd9;
  localparam logic [4:0] ST_INV_ALIGN = 5'd10;
  localparam logic [4:0] ST_INV_SUB   = 5'd11;
  localparam logic [4:0] ST_INV_FIX   = 5'd12;
  localparam logic [4:0] ST_LAM       = 5'd13;
  localparam logic [4:0] ST_LSQ       = 5'd14;
  localparam logic [4:0] ST_RX2       = 5'd15;
  localparam logic [4:0] ST_D         = 5'd16;
  localparam logic [4:0] ST_RY        = 5'd17;
  localparam logic [4:0] ST_FIN       = 5'd18;

  // configuration registers
  logic [W-1:0] modulus;
  logic [W-1:0] curve_a;

  // sequencer
  logic [4:0]  state;
  logic [4:0]  ret;
  logic [KW-1:0] cnt;
  logic [KW-1:0] k;

  // working registers
  logic [W-1:0] x1, y1, x2, y2;
  logic [W-1:0] acc, mm, mb;
  logic [W-1:0] ar, num, lam;
  logic [W-1:0] rx, ry;
  logic         res_inf, res_bad;
  logic [W-1:0] r0, r1;
  logic signed [SW-1:0] s0, s1;

  alu_req_t     alu_req;
  logic [W-1:0] alu_res;

  // ---------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_MODULUS: prdata = 32'(modulus);
      REG_CURVE_A: prdata = 32'(curve_a);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // beat checks at the input
  // ---------------------------------------------------------------
  logic bad1, bad2, in_bad, x_eq;
  assign bad1   = !points.first_inf &&
                  ((points.first_x >= modulus) || (points.first_y >= modulus));
  assign bad2   = !points.second_inf &&
                  ((points.second_x >= modulus) || (points.second_y >= modulus));
  assign in_bad = bad1 || bad2;
  assign x_eq   = points.first_x == points.second_x;

  assign points_ready = (state == ST_IDLE);

  // ---------------------------------------------------------------
  // shared ALU operand select
  // ---------------------------------------------------------------
  always_comb begin
    alu_req      = '0;
    alu_req.p    = modulus;
    alu_req.op   = ALU_ADD;
    case (state)
      ST_MUL: begin
        alu_req.op   = ALU_MSTEP;
        alu_req.a    = acc;
        alu_req.b    = mb;
        alu_req.mbit = mm[W-1];
      end
      ST_SQ: begin
        alu_req.a = acc;
        alu_req.b = acc;
      end
      ST_T3: begin
        alu_req.a = num;
        alu_req.b = acc;
      end
      ST_TA: begin
        alu_req.a = num;
        alu_req.b = ar;
      end
      ST_DDEN: begin
        alu_req.a = y1;
        alu_req.b = y1;
      end
      ST_CNUM: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = y2;
        alu_req.b  = y1;
      end
      ST_CDEN: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = x2;
        alu_req.b  = x1;
      end
      ST_LSQ: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = acc;
        alu_req.b  = x1;
      end
      ST_RX2: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = rx;
        alu_req.b  = x2;
      end
      ST_D: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = x1;
        alu_req.b  = rx;
      end
      ST_RY: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = acc;
        alu_req.b  = y1;
      end
      default: begin
        alu_req.a = '0;
        alu_req.b = '0;
      end
    endcase
  end

  ecpa_modalu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // ---------------------------------------------------------------
  // extended Euclid datapath: shift-subtract quotient, Bezout update
  // ---------------------------------------------------------------
  logic [2*W-1:0]       r0_wide, r1_wide, sd_wide;
  logic [KW:0]          k_inc;
  logic                 align_ok, sub_ok;
  logic [W-1:0]         r0_next;
  logic signed [SW-1:0] s0_next;
  logic signed [SW-1:0] p_s, fix1, fix2;
  logic [W-1:0]         inv;

  assign r0_wide  = {{W{1'b0}}, r0};
  assign r1_wide  = {{W{1'b0}}, r1};
  assign k_inc    = {1'b0, k} + 1'b1;
  assign align_ok = (r1_wide << k_inc) <= r0_wide;
  assign sd_wide  = r1_wide << k;
  assign sub_ok   = sd_wide <= r0_wide;
  assign r0_next  = sub_ok ? r0 - sd_wide[W-1:0] : r0;
  assign s0_next  = sub_ok ? s0 - (s1 <<< k) : s0;

  // bring the coefficient into [0, p)
  assign p_s  = $signed({2'b00, modulus});
  assign fix1 = s0[SW-1] ? s0 + p_s : s0;
  assign fix2 = (fix1 >= p_s) ? fix1 - p_s : fix1;
  assign inv  = fix2[W-1:0];

  // ---------------------------------------------------------------
  // sequencer, working registers and output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      sum_valid <= 1'b0;
      modulus   <= MODULUS_RESET;
      curve_a   <= CURVE_A_RESET;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_MODULUS: modulus <= pwdata[W-1:0];
          REG_CURVE_A: curve_a <= pwdata[W-1:0];
          default: ;
        endcase
      end

      // output beat taken and no new sum loaded this cycle
      if (sum_valid && sum_ready && (state != ST_FIN)) begin
        sum_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (points_valid) begin
            x1      <= points.first_x;
            y1      <= points.first_y;
            x2      <= points.second_x;
            y2      <= points.second_y;
            res_bad <= in_bad;
            if (in_bad) begin
              res_inf <= 1'b0;
              rx      <= '0;
              ry      <= '0;
              state   <= ST_FIN;
            end else if (points.first_inf && points.second_inf) begin
              res_inf <= 1'b1;
              rx      <= '0;
              ry      <= '0;
              state   <= ST_FIN;
            end else if (points.first_inf) begin
              res_inf <= 1'b0;
              rx      <= points.second_x;
              ry      <= points.second_y;
              state   <= ST_FIN;
            end else if (points.second_inf) begin
              res_inf <= 1'b0;
              rx      <= points.first_x;
              ry      <= points.first_y;
              state   <= ST_FIN;
            end else if (x_eq && ((points.first_y != points.second_y) ||
                                  (points.first_y == '0))) begin
              res_inf <= 1'b1;
              rx      <= '0;
              ry      <= '0;
              state   <= ST_FIN;
            end else if (x_eq) begin
              // doubling: reduce a first
              res_inf <= 1'b0;
              acc     <= '0;
              mm      <= curve_a;
              mb      <= W'(1);
              cnt     <= '0;
              ret     <= ST_AR;
              state   <= ST_MUL;
            end else begin
              res_inf <= 1'b0;
              state   <= ST_CNUM;
            end
          end
        end

        // one multiplier bit per cycle, MSB first
        ST_MUL: begin
          acc <= alu_res;
          mm  <= {mm[W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == KW'(W - 1)) begin
            state <= ret;
          end
        end

        ST_AR: begin
          ar    <= acc;
          acc   <= '0;
          mm    <= x1;
          mb    <= x1;
          cnt   <= '0;
          ret   <= ST_SQ;
          state <= ST_MUL;
        end

        ST_SQ: begin
          num   <= alu_res;
          state <= ST_T3;
        end

        ST_T3: begin
          num   <= alu_res;
          state <= ST_TA;
        end

        ST_TA: begin
          num   <= alu_res;
          state <= ST_DDEN;
        end

        ST_DDEN: begin
          r0    <= alu_res;
          r1    <= modulus;
          s0    <= SW'(1);
          s1    <= '0;
          k     <= '0;
          state <= ST_INV_TEST;
        end

        ST_CNUM: begin
          num   <= alu_res;
          state <= ST_CDEN;
        end

        ST_CDEN: begin
          r0    <= alu_res;
          r1    <= modulus;
          s0    <= SW'(1);
          s1    <= '0;
          k     <= '0;
          state <= ST_INV_TEST;
        end

        ST_INV_TEST: begin
          state <= (r1 == '0) ? ST_INV_FIX : ST_INV_ALIGN;
        end

        // grow the divisor shift until the next doubling overshoots
        ST_INV_ALIGN: begin
          if (align_ok) begin
            k <= k_inc[KW-1:0];
          end else begin
            state <= ST_INV_SUB;
          end
        end

        // one quotient bit; at the last bit rotate the remainder pair
        ST_INV_SUB: begin
          if (k == '0) begin
            r0    <= r1;
            r1    <= r0_next;
            s0    <= s1;
            s1    <= s0_next;
            state <= ST_INV_TEST;
          end else begin
            r0 <= r0_next;
            s0 <= s0_next;
            k  <= k - 1'b1;
          end
        end

        ST_INV_FIX: begin
          acc   <= '0;
          mm    <= num;
          mb    <= inv;
          cnt   <= '0;
          ret   <= ST_LAM;
          state <= ST_MUL;
        end

        ST_LAM: begin
          lam   <= acc;
          mm    <= acc;
          mb    <= acc;
          acc   <= '0;
          cnt   <= '0;
          ret   <= ST_LSQ;
          state <= ST_MUL;
        end

        ST_LSQ: begin
          rx    <= alu_res;
          state <= ST_RX2;
        end

        ST_RX2: begin
          rx    <= alu_res;
          state <= ST_D;
        end

        ST_D: begin
          mm    <= alu_res;
          mb    <= lam;
          acc   <= '0;
          cnt   <= '0;
          ret   <= ST_RY;
          state <= ST_MUL;
        end

        ST_RY: begin
          ry      <= alu_res;
          res_inf <= 1'b0;
          state   <= ST_FIN;
        end

        // hand over to the output register once it is free
        ST_FIN: begin
          if (!sum_valid || sum_ready) begin
            sum.sum_inf   <= res_inf;
            sum.sum_x     <= rx;
            sum.sum_y     <= ry;
            sum.bad_input <= res_bad;
            sum_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  `ASSERT_IMPLIES(a_inf_zero, clk, rst, sum_valid && sum.sum_inf,
                  sum.sum_x == '0 && sum.sum_y == '0)
  `ASSERT_IMPLIES(a_bad_clean, clk, rst, sum_valid && sum.bad_input,
                  !sum.sum_inf && sum.sum_x == '0 && sum.sum_y == '0)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, points_valid && points_ready, !points_ready)
  `ASSERT_IMPLIES(a_divisor_nonzero, clk, rst,
                  state == ST_INV_ALIGN || state == ST_INV_SUB, r1 != '0)

endmodule

>>> rtl/ecpa_modalu.sv
// Shared modular ALU: add, subtract and one double-and-add step mod p.
// Depends on ecpa_pkg.
`timescale 1ns / 1ps

module ecpa_modalu (
  input  ecpa_pkg::alu_req_t                  req,
  output logic [ecpa_pkg::FIELD_BITS-1:0]     res
);
  import ecpa_pkg::*;

  logic [FIELD_BITS:0] p_e;
  logic [FIELD_BITS:0] a_e;
  logic [FIELD_BITS:0] b_e;
  logic [FIELD_BITS:0] dbl;
  logic [FIELD_BITS:0] dbl_red;
  logic [FIELD_BITS:0] lhs;
  logic [FIELD_BITS:0] rhs;
  logic [FIELD_BITS:0] add_raw;
  logic [FIELD_BITS:0] add_red;
  logic [FIELD_BITS:0] sub_res;

  assign p_e = {1'b0, req.p};
  assign a_e = {1'b0, req.a};
  assign b_e = {1'b0, req.b};

  // step: 2a mod p, then optionally + b (b no larger than p)
  assign dbl     = {req.a, 1'b0};
  assign dbl_red = (dbl >= p_e) ? dbl - p_e : dbl;

  // one adder shared by add and step, sum stays below 2p
  assign lhs     = (req.op == ALU_MSTEP) ? dbl_red : a_e;
  assign rhs     = (req.op == ALU_MSTEP) ? (req.mbit ? b_e : '0) : b_e;
  assign add_raw = lhs + rhs;
  assign add_red = (add_raw >= p_e) ? add_raw - p_e : add_raw;

  // a - b mod p, wrap by adding p back
  assign sub_res = (a_e >= b_e) ? a_e - b_e : a_e + p_e - b_e;

  always_comb begin
    case (req.op)
      ALU_ADD:   res = add_red[FIELD_BITS-1:0];
      ALU_MSTEP: res = add_red[FIELD_BITS-1:0];
      ALU_SUB:   res = sub_res[FIELD_BITS-1:0];
      default:   res = '0;
    endcase
  end

endmodule
